/* src/morton_tile_pixel_packer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Morton tile pixel packer
// Shared concurrent assertion wrappers, clocked on clk, with or without an arst_n disable.
// ----------------------------------------------------------------------------
`ifndef MORTON_TILE_PIXEL_PACKER_UNIT_MACROS_SVH
`define MORTON_TILE_PIXEL_PACKER_UNIT_MACROS_SVH

// Assertion sampled on clk, switched off while reset is asserted
`define MTPP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds during reset
`define MTPP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mtpp_pkg.sv */
// ----------------------------------------------------------------------------
// Morton tile pixel packer package
// Field widths, register and format codes, and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mtpp_pkg;

	// Field widths
	localparam int POS_W     = 10;
	localparam int CHAN_W    = 8;
	localparam int TEXEL_W   = 16;
	localparam int INDEX_W   = 20;
	localparam int FMT_W     = 2;
	localparam int TPR_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = TPR_W;

	// Tile geometry: 8x8 tiles, 64 texels each
	localparam int TILE_LOG2 = 3;
	localparam int MORTON_W  = 2 * TILE_LOG2;
	localparam int TCOORD_W  = POS_W - TILE_LOG2;
	localparam int TILE_W    = TCOORD_W + TPR_W + 1;
	localparam int LIMIT_W   = TPR_W + TILE_LOG2;

	// Largest image side; rows wrap at this value (power of two)
	localparam int MAX_SIDE = 1024;
	localparam logic [POS_W-1:0] Y_WRAP_MASK = POS_W'(MAX_SIDE - 1);

	// Reset value of tiles_per_row
	localparam logic [TPR_W-1:0] TPR_RESET = TPR_W'(1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_FORMAT  = 1'b0,
		REG_TILES_PER_ROW = 1'b1
	} cfg_reg_t;

	// Texel formats; the remaining codes give zero texels
	typedef enum logic [FMT_W-1:0] {
		FMT_RGB565_PREMUL = 2'd0,
		FMT_RGBA4444      = 2'd1,
		FMT_NONE          = 2'd2
	} pix_fmt_t;

	// floor(p / 255) for p up to 255*255, without a divider
	function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
		logic [2*CHAN_W:0] t;
		t = (2*CHAN_W+1)'(p) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
		return t[2*CHAN_W-1:CHAN_W];
	endfunction

	// Interleave local x and y: x bit 0 lowest, then y bit 0, and so on
	function automatic logic [MORTON_W-1:0] morton_local(
		input logic [TILE_LOG2-1:0] lx,
		input logic [TILE_LOG2-1:0] ly
	);
		logic [MORTON_W-1:0] m;
		for (int i = 0; i < TILE_LOG2; i++) begin
			m[2*i]   = lx[i];
			m[2*i+1] = ly[i];
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* src/mtpp_if.sv */
// ----------------------------------------------------------------------------
// Morton tile pixel packer channel interfaces
// Valid/ready channels for source pixels and packed texels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtpp_pix_if;
	import mtpp_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;

	modport source (output valid, pos_x, pos_y, red, green, blue, alpha, input ready);
	modport sink   (input valid, pos_x, pos_y, red, green, blue, alpha, output ready);
endinterface

interface mtpp_tex_if;
	import mtpp_pkg::*;

	logic               valid;
	logic               ready;
	logic [TEXEL_W-1:0] texel;
	logic [INDEX_W-1:0] dest_index;
	logic               outside;

	modport source (output valid, texel, dest_index, outside, input ready);
	modport sink   (input valid, texel, dest_index, outside, output ready);
endinterface

`default_nettype wire

/* src/morton_tile_pixel_packer_unit.sv */
// ----------------------------------------------------------------------------
// Morton tile pixel packer
// Packs RGBA8888 pixels into 16-bit texels and places them in 8x8 Morton tiles.
// ----------------------------------------------------------------------------
// Usage:
//   pix : valid/ready sink, one pixel (column, row, RGBA8888) per transaction.
//   tex : valid/ready source, one texel, its word index in the tiled buffer
//         and the past-width flag per transaction, in input order.
//   cfg_we/cfg_index/cfg_wdata : register writes, only while the block is idle
//         (index 0 pixel format, index 1 tiles per row).
// Path: an accepted pixel passes the input register, then the result register,
//   which drives tex. Throughput: one pixel per cycle, back to back, while tex
//   is taken; the two registers each hold one transaction, and the texel logic
//   (one 8x8 multiply per channel plus the /255 correction) sits between them.
// Stall: when tex is not taken, the result register holds, the input register
//   still fills once, and pix.ready then drops until tex moves again.
// Reset: arst_n clears both valid flags, pixel format to RGB565 premultiplied
//   and tiles per row to one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "morton_tile_pixel_packer_unit_macros.svh"

module morton_tile_pixel_packer_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	mtpp_pix_if.sink                          pix,
	mtpp_tex_if.source                        tex,
	input  wire logic                         cfg_we,
	input  wire logic [mtpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mtpp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mtpp_pkg::*;

	// Configuration registers
	pix_fmt_t          fmt_q;
	logic [TPR_W-1:0]  tpr_q;

	// Input register
	logic              valid_s1;
	logic [POS_W-1:0]  x_s1;
	logic [POS_W-1:0]  y_s1;
	logic [CHAN_W-1:0] r_s1;
	logic [CHAN_W-1:0] g_s1;
	logic [CHAN_W-1:0] b_s1;
	logic [CHAN_W-1:0] a_s1;

	// Result register
	logic               out_valid_q;
	logic [TEXEL_W-1:0] texel_q;
	logic [INDEX_W-1:0] dest_index_q;
	logic               outside_q;

	// Combinational results
	logic                advance_s1;
	logic [POS_W-1:0]    y_wrap;
	logic [TILE_W-1:0]   tile_num;
	logic [MORTON_W-1:0] morton;
	logic [INDEX_W-1:0]  dest_index_d;
	logic                outside_d;
	logic [2*CHAN_W-1:0] prod_r;
	logic [2*CHAN_W-1:0] prod_g;
	logic [2*CHAN_W-1:0] prod_b;
	logic [CHAN_W-1:0]   pm_r;
	logic [CHAN_W-1:0]   pm_g;
	logic [CHAN_W-1:0]   pm_b;
	logic [TEXEL_W-1:0]  texel_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB565_PREMUL;
			tpr_q <= TPR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PIXEL_FORMAT:  fmt_q <= pix_fmt_t'(cfg_wdata[FMT_W-1:0]);
				REG_TILES_PER_ROW: tpr_q <= cfg_wdata[TPR_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance_s1 = !out_valid_q || tex.ready;
	assign pix.ready  = !valid_s1 || advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			x_s1 <= pix.pos_x;
			y_s1 <= pix.pos_y;
			r_s1 <= pix.red;
			g_s1 <= pix.green;
			b_s1 <= pix.blue;
			a_s1 <= pix.alpha;
		end
	end

	// Tile address: tile number times 64 plus the Morton offset
	always_comb begin
		y_wrap       = y_s1 & Y_WRAP_MASK;
		tile_num     = TILE_W'(y_wrap[POS_W-1:TILE_LOG2]) * TILE_W'(tpr_q)
		             + TILE_W'(x_s1[POS_W-1:TILE_LOG2]);
		morton       = morton_local(x_s1[TILE_LOG2-1:0], y_wrap[TILE_LOG2-1:0]);
		dest_index_d = INDEX_W'({tile_num, morton});
		outside_d    = LIMIT_W'(x_s1) >= {tpr_q, TILE_LOG2'(0)};
	end

	// Premultiplied channels, exact floor(c*a/255)
	always_comb begin
		prod_r = r_s1 * a_s1;
		prod_g = g_s1 * a_s1;
		prod_b = b_s1 * a_s1;
		pm_r   = div255(prod_r);
		pm_g   = div255(prod_g);
		pm_b   = div255(prod_b);
	end

	// Texel packing per format
	always_comb begin
		case (fmt_q)
			FMT_RGB565_PREMUL: texel_d = {pm_r[7:3], pm_g[7:2], pm_b[7:3]};
			FMT_RGBA4444:      texel_d = {r_s1[7:4], g_s1[7:4], b_s1[7:4], a_s1[7:4]};
			default:           texel_d = '0;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && valid_s1) begin
			texel_q      <= texel_d;
			dest_index_q <= dest_index_d;
			outside_q    <= outside_d;
		end
	end

	assign tex.valid      = out_valid_q;
	assign tex.texel      = texel_q;
	assign tex.dest_index = dest_index_q;
	assign tex.outside    = outside_q;

	// Checks
	`MTPP_ASSERT(a_full_blocks_input, valid_s1 && out_valid_q && !tex.ready |-> !pix.ready, "input taken while both registers are full and output stalled")
	`MTPP_ASSERT(a_accept_fills_s1, pix.valid && pix.ready |=> valid_s1, "accepted transaction lost before stage 1")
	`MTPP_ASSERT(a_s1_moves_out, valid_s1 && advance_s1 |=> out_valid_q, "stage 1 transaction not moved into result register")
	`MTPP_ASSERT(a_out_from_s1, $rose(out_valid_q) |-> $past(valid_s1), "result appeared without a stage 1 transaction")
	`MTPP_ASSERT_ALWAYS(a_reset_clears, !arst_n |=> !valid_s1 && !out_valid_q, "valid flags set during reset")

endmodule

`default_nettype wire

/* sim/morton_tile_pixel_packer_unit_tb.sv */
// ----------------------------------------------------------------------------
// Morton tile pixel packer testbench
// Streams pixels through the packer under several register settings and
// handshake idling patterns. A scoreboard predicts each texel, its tiled word
// index and the past-width flag, and checks every output transaction in order.
// ----------------------------------------------------------------------------

import mtpp_pkg::*;

typedef struct packed {
	logic [TEXEL_W-1:0] texel;
	logic [INDEX_W-1:0] dest_index;
	logic               outside;
} texel_result_t;

class texel_scoreboard;
	texel_result_t    texel_q[$];
	logic [FMT_W-1:0] fmt;
	logic [TPR_W-1:0] tpr;
	int               errors;
	int               fmt_count[4];
	int               outside_count;

	function new();
		fmt = FMT_RGB565_PREMUL;
		tpr = TPR_RESET;
	endfunction

	function void set_config(logic [FMT_W-1:0] f, logic [TPR_W-1:0] t);
		fmt = f;
		tpr = t;
	endfunction

	function int pending();
		return texel_q.size();
	endfunction

	// Texel packing and tiled placement of one pixel under the current settings
	function texel_result_t predict_texel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
		logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
		logic [CHAN_W-1:0] a);
		int unsigned   rp, gp, bp, tile, idx;
		logic [5:0]    zorder;
		texel_result_t res;
		case (fmt)
			FMT_RGB565_PREMUL: begin
				// exact floor(c*a/255)
				rp = (32'(r) * 32'(a)) / 255;
				gp = (32'(g) * 32'(a)) / 255;
				bp = (32'(b) * 32'(a)) / 255;
				res.texel = {rp[7:3], gp[7:2], bp[7:3]};
			end
			FMT_RGBA4444: res.texel = {r[7:4], g[7:4], b[7:4], a[7:4]};
			default:      res.texel = '0;
		endcase
		zorder = {y[2], x[2], y[1], x[1], y[0], x[0]};
		tile   = (32'(y) >> 3) * 32'(tpr) + (32'(x) >> 3);
		idx    = tile * 64 + 32'(zorder);
		res.dest_index = idx[INDEX_W-1:0];
		res.outside    = (32'(x) >= 32'(tpr) * 8);
		return res;
	endfunction

	function void note_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
		logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
		logic [CHAN_W-1:0] a);
		texel_result_t res;
		res = predict_texel(x, y, r, g, b, a);
		texel_q.push_back(res);
		fmt_count[fmt]++;
		if (res.outside)
			outside_count++;
	endfunction

	function void check_texel(logic [TEXEL_W-1:0] t, logic [INDEX_W-1:0] di, logic o);
		texel_result_t exp_res;
		if (texel_q.size() == 0) begin
			$display("%0t: texel with nothing expected: texel %h index %h outside %b",
				$time, t, di, o);
			errors++;
			return;
		end
		exp_res = texel_q.pop_front();
		if (t !== exp_res.texel) begin
			$display("%0t: texel mismatch: expected %h, actual %h", $time, exp_res.texel, t);
			errors++;
		end
		if (di !== exp_res.dest_index) begin
			$display("%0t: dest_index mismatch: expected %h, actual %h",
				$time, exp_res.dest_index, di);
			errors++;
		end
		if (o !== exp_res.outside) begin
			$display("%0t: outside mismatch: expected %b, actual %b", $time, exp_res.outside, o);
			errors++;
		end
	endfunction
endclass

module morton_tile_pixel_packer_unit_tb;

	localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
	localparam int BLOCK_ITEMS = 150;
	localparam int LONG_HOLD   = 300;
	localparam int STUCK_LIMIT = 5000;

	// Per random block: pixel format and tiles per row (-1 picks one at random)
	localparam logic [FMT_W-1:0] FMT_PLAN [8] = '{FMT_RGB565_PREMUL, FMT_RGBA4444,
		FMT_NONE, FMT_SPARE, FMT_RGB565_PREMUL, FMT_RGBA4444, FMT_RGB565_PREMUL,
		FMT_RGBA4444};
	localparam int TPR_PLAN [8]   = '{1, 128, 0, 255, -1, -1, 128, 1};
	// Per idling phase (two blocks each), in percent of cycles
	localparam int SRC_IDLE [4]   = '{0, 79, 0, 18};
	localparam int SINK_STALL [4] = '{0, 0, 79, 18};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mtpp_pix_if pix ();
	mtpp_tex_if tex ();

	texel_scoreboard sb;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_requests;
	int stuck_cycles;
	int settings_used;

	morton_tile_pixel_packer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.tex       (tex),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix.valid && pix.ready)
				sb.note_pixel(pix.pos_x, pix.pos_y, pix.red, pix.green, pix.blue, pix.alpha);
			if (tex.valid && tex.ready)
				sb.check_texel(tex.texel, tex.dest_index, tex.outside);
			if ((pix.valid && pix.ready) || (tex.valid && tex.ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Texel sink: random stalls, plus a long hold whenever one is requested
	initial begin : texel_sink
		int holds_served;
		holds_served = 0;
		tex.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests > holds_served) begin
				holds_served++;
				tex.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			tex.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Write both registers; only called with nothing in flight
	task automatic apply_config(input logic [CFG_DATA_W-1:0] fmt_data,
		input logic [CFG_DATA_W-1:0] tpr_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PIXEL_FORMAT;
		cfg_wdata <= fmt_data;
		@(posedge clk);
		cfg_index <= REG_TILES_PER_ROW;
		cfg_wdata <= tpr_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(fmt_data[FMT_W-1:0], tpr_data);
		settings_used++;
	endtask

	// Offer one pixel, with an optional idle gap first; returns on acceptance
	task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		pix.valid <= 1'b1;
		pix.pos_x <= x;
		pix.pos_y <= y;
		pix.red   <= r;
		pix.green <= g;
		pix.blue  <= b;
		pix.alpha <= a;
		do @(posedge clk); while (!pix.ready);
	endtask

	// Stop offering and wait for every outstanding texel
	task automatic drain();
		pix.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Mostly uniform, one in five at an extreme
	function automatic logic [CHAN_W-1:0] rand_chan();
		if ($urandom_range(4) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return CHAN_W'($urandom_range(255));
	endfunction

	initial begin : stimulus
		int                 tpr_val;
		int unsigned        span;
		logic [POS_W-1:0]   x;
		logic [CFG_DATA_W-1:0] fmt_data;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PIXEL_FORMAT;
		cfg_wdata = '0;
		pix.valid = 1'b0;
		pix.pos_x = '0;
		pix.pos_y = '0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		pix.alpha = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_requests = 0;
		stuck_cycles = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings (RGB565, one tile per row)
		send_pixel(0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(1023, 1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(7, 7, 8'hFF, 8'h80, 8'h01, 8'hFF);
		send_pixel(5, 3, 8'hC8, 8'h64, 8'h32, 8'h00);
		send_pixel(2, 6, 8'hFF, 8'hFF, 8'hFF, 8'h01);
		send_pixel(8, 0, 8'h11, 8'h22, 8'h33, 8'h80);
		drain();
		// RGBA4444 with junk in the upper data bits, widest legal image
		apply_config(8'hFD, 8'd128);
		send_pixel(1023, 1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(0, 0, 8'h0F, 8'hF0, 8'h5A, 8'hA5);
		send_pixel(640, 517, 8'h80, 8'h7F, 8'h01, 8'hFE);
		drain();
		// Unsupported format, index wraps past 2^20
		apply_config(FMT_NONE, 8'd255);
		send_pixel(1023, 1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(1019, 1022, 8'h01, 8'h02, 8'h03, 8'h04);
		drain();
		// Spare format code, zero tiles per row: everything is past the width
		apply_config(FMT_SPARE, 8'd0);
		send_pixel(17, 9, 8'hC8, 8'hC8, 8'hC8, 8'hC8);
		send_pixel(0, 0, 8'hFF, 8'h00, 8'hFF, 8'h00);
		send_pixel(1023, 1016, 8'h00, 8'hFF, 8'h00, 8'hFF);
		drain();

		// Random blocks, two per idling phase
		for (int blk = 0; blk < 8; blk++) begin
			src_idle_pct   = SRC_IDLE[blk / 2];
			sink_stall_pct = SINK_STALL[blk / 2];
			tpr_val = (TPR_PLAN[blk] < 0) ? int'($urandom_range(127, 2)) : TPR_PLAN[blk];
			fmt_data = {6'($urandom_range(63)), FMT_PLAN[blk]};
			apply_config(fmt_data, CFG_DATA_W'(tpr_val));
			// long sink hold while pixels keep coming, so the input side backs up
			if (blk == 0 || blk == 6)
				hold_requests++;
			span = (tpr_val * 8 > 1024) ? 1024 : tpr_val * 8;
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				if (span != 0 && $urandom_range(3) != 0)
					x = POS_W'($urandom_range(span - 1));
				else
					x = POS_W'($urandom_range(1023));
				send_pixel(x, POS_W'($urandom_range(1023)), rand_chan(), rand_chan(),
					rand_chan(), rand_chan());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d pixels over %0d register settings, four idling patterns and two long sink holds.",
			14 + 8 * BLOCK_ITEMS, settings_used);
		$display("Formats: %0d RGB565, %0d RGBA4444, %0d zero-texel; %0d pixels past the width.",
			sb.fmt_count[0], sb.fmt_count[1], sb.fmt_count[2] + sb.fmt_count[3],
			sb.outside_count);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d texels never seen", sb.errors, sb.pending());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/mtpp_pkg.sv
src/mtpp_if.sv
src/morton_tile_pixel_packer_unit.sv
sim/morton_tile_pixel_packer_unit_tb.sv
